@@ rtl/ray_box_face_intersect_assert.svh @@
// ----------------------------------------------------------------------------
// ray box face intersect assertion macros
// concurrent checks that compile away under synthesis
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_FACE_INTERSECT_ASSERT_SVH
`define RAY_BOX_FACE_INTERSECT_ASSERT_SVH

`ifndef SYNTHESIS

`define RBFI_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`define RBFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RBFI_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define RBFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/rbfi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbfi_pkg
// shared types and constants of the ray against box face intersect block
// ----------------------------------------------------------------------------
package rbfi_pkg;

    localparam int QUEUE_DEPTH  = 4;
    // items that can be in the front stages when a new one is taken, plus it
    localparam int FRONT_SLOTS  = 3;
    localparam int EPS_Q        = 66;
    localparam int COORD_W      = 32;
    localparam int FACE_W       = 3;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Z = 3'd5;

    localparam logic [COORD_W-1:0] BOX_LOW_RESET  = 32'h0000_0000;
    localparam logic [COORD_W-1:0] BOX_HIGH_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] start;
        logic [2:0][COORD_W-1:0] dir;
        logic [63:0]             sum;
        logic                    dir_zero;
    } ray_t;

    typedef struct packed {
        logic empty;
        logic room;
    } queue_status_t;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [FACE_W-1:0]  face;
        logic [COORD_W-1:0] distance;
    } result_t;

endpackage

@@ rtl/rbfi_front.sv @@
// ----------------------------------------------------------------------------
// rbfi_front
// takes rays, squares the direction and flags a zero direction
// ----------------------------------------------------------------------------
module rbfi_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [2:0][rbfi_pkg::COORD_W-1:0] start_pos,
    input  logic [2:0][rbfi_pkg::COORD_W-1:0] dir,
    output logic                              push,
    output rbfi_pkg::ray_t                    push_data
);

    logic                              s1_valid_reg;
    logic [2:0][rbfi_pkg::COORD_W-1:0] s1_start_reg;
    logic [2:0][rbfi_pkg::COORD_W-1:0] s1_dir_reg;
    logic                              s2_valid_reg;
    logic [2:0][rbfi_pkg::COORD_W-1:0] s2_start_reg;
    logic [2:0][rbfi_pkg::COORD_W-1:0] s2_dir_reg;
    logic [2:0][62:0]                  s2_sq_reg;
    logic                              s2_zero_reg;
    logic [2:0][62:0]                  sq_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_next[k] = 63'($signed(s1_dir_reg[k]) * $signed(s1_dir_reg[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_start_reg <= start_pos;
            s1_dir_reg   <= dir;
        end
        s2_start_reg <= s1_start_reg;
        s2_dir_reg   <= s1_dir_reg;
        s2_sq_reg    <= sq_next;
        s2_zero_reg  <= (s1_dir_reg == '0);
    end

    assign push               = s2_valid_reg;
    assign push_data.start    = s2_start_reg;
    assign push_data.dir      = s2_dir_reg;
    // three squares of at most 2^62 fit in 64 bits
    assign push_data.sum      = {1'b0, s2_sq_reg[0]} + {1'b0, s2_sq_reg[1]}
                              + {1'b0, s2_sq_reg[2]};
    assign push_data.dir_zero = s2_zero_reg;

endmodule

@@ rtl/rbfi_queue.sv @@
// ----------------------------------------------------------------------------
// rbfi_queue
// short queue between the front and the back
// ----------------------------------------------------------------------------
`include "ray_box_face_intersect_assert.svh"

module rbfi_queue #(
    parameter int DEPTH = rbfi_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rbfi_pkg::ray_t          push_data,
    input  logic                    pop,
    output rbfi_pkg::ray_t          pop_data,
    output rbfi_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rbfi_pkg::ray_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.room  = (int'(count_reg) + rbfi_pkg::FRONT_SLOTS) <= DEPTH;

    `RBFI_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && !pop && count_reg == CNT_W'(DEPTH),
        "queue written while full")
    `RBFI_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && count_reg == '0,
        "queue read while empty")
    `RBFI_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count lost a beat")

endmodule

@@ rtl/rbfi_div.sv @@
// ----------------------------------------------------------------------------
// rbfi_div
// pipelined restoring divider, one quotient bit per stage, shared lanes
// ----------------------------------------------------------------------------
module rbfi_div #(
    parameter int LANES = 1,
    parameter int NW    = 48,
    parameter int DW    = 17,
    parameter int QW    = 42,
    parameter int SW    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   num,
    input  logic [LANES-1:0][DW-1:0]   den,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   quo,
    output logic [SW-1:0]              out_side
);

    localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic                     valid_reg [1:QW];
    logic [LANES-1:0][NW-1:0] rem_reg   [1:QW];
    logic [LANES-1:0][DW-1:0] den_reg   [1:QW];
    logic [LANES-1:0][QW-1:0] quo_reg   [1:QW];
    logic [SW-1:0]            side_reg  [1:QW];

    genvar i, l;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            localparam int B = QW - 1 - i;
            logic                     v_cur;
            logic [LANES-1:0][NW-1:0] rem_cur;
            logic [LANES-1:0][DW-1:0] den_cur;
            logic [LANES-1:0][QW-1:0] quo_cur;
            logic [SW-1:0]            side_cur;
            logic [LANES-1:0][NW-1:0] rem_next;
            logic [LANES-1:0][QW-1:0] quo_next;

            if (i == 0)
            begin : g_src
                assign v_cur    = in_valid;
                assign rem_cur  = num;
                assign den_cur  = den;
                assign quo_cur  = '0;
                assign side_cur = in_side;
            end
            else
            begin : g_src
                assign v_cur    = valid_reg[i];
                assign rem_cur  = rem_reg[i];
                assign den_cur  = den_reg[i];
                assign quo_cur  = quo_reg[i];
                assign side_cur = side_reg[i];
            end

            for (l = 0; l < LANES; l++)
            begin : g_lane
                logic [CW-1:0] rem_ext;
                logic [CW-1:0] den_sh;
                logic [CW-1:0] diff;
                logic          ge;

                assign rem_ext     = {{(CW - NW){1'b0}}, rem_cur[l]};
                assign den_sh      = {{(CW - DW){1'b0}}, den_cur[l]} << B;
                assign ge          = rem_ext >= den_sh;
                assign diff        = rem_ext - den_sh;
                assign rem_next[l] = ge ? diff[NW-1:0] : rem_cur[l];
                assign quo_next[l] = quo_cur[l] | (QW'(ge) << B);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i+1] <= 1'b0;
                end
                else
                begin
                    valid_reg[i+1] <= v_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i+1]  <= rem_next;
                den_reg[i+1]  <= den_cur;
                quo_reg[i+1]  <= quo_next;
                side_reg[i+1] <= side_cur;
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW];
    assign quo       = quo_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

@@ rtl/rbfi_back.sv @@
// ----------------------------------------------------------------------------
// rbfi_back
// normalizes the direction, solves all six faces and picks the nearest hit
// ----------------------------------------------------------------------------
module rbfi_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  rbfi_pkg::ray_t                    in_ray,
    input  logic [2:0][rbfi_pkg::COORD_W-1:0] box_low,
    input  logic [2:0][rbfi_pkg::COORD_W-1:0] box_high,
    output logic                              out_valid,
    output rbfi_pkg::result_t                 out_result
);

    localparam int SQ_STAGES = 32;
    localparam int LEN_W     = 33;
    localparam int UQ_W      = 17;
    localparam int U_W       = 18;
    localparam int TQ_W      = 42;
    localparam int T_W       = 43;
    localparam int PROD_W    = 61;
    localparam int P_W       = 45;
    localparam int NUM_W     = 48;

    localparam logic signed [T_W-1:0] T_MIN = -T_W'(rbfi_pkg::EPS_Q);

    typedef logic [2:0][rbfi_pkg::COORD_W-1:0] vec_t;

    typedef struct packed {
        vec_t       start;
        logic [2:0] neg;
        logic       zero;
    } unit_side_t;

    typedef struct packed {
        logic [2:0][U_W-1:0] u;
        vec_t                start;
        logic [2:0]          ok;
        logic                zero;
        logic [5:0]          tneg;
    } face_side_t;

    typedef struct packed {
        logic                     found;
        logic [T_W-1:0]           t;
        logic [2:0][P_W-1:0]      p;
        logic [rbfi_pkg::FACE_W-1:0] face;
    } cand_t;

    function automatic cand_t pick(input cand_t first, input cand_t second);
        if (second.found && (!first.found || $signed(second.t) < $signed(first.t)))
        begin
            pick = second;
        end
        else
        begin
            pick = first;
        end
    endfunction

    function automatic logic [rbfi_pkg::COORD_W-1:0] sat32(input logic [P_W-1:0] v);
        if (v[P_W-1:31] == '0 || v[P_W-1:31] == '1)
        begin
            sat32 = v[31:0];
        end
        else if (v[P_W-1])
        begin
            sat32 = 32'h8000_0000;
        end
        else
        begin
            sat32 = 32'h7FFF_FFFF;
        end
    endfunction

    // ---------------- square root, one root bit per stage ----------------
    logic        sq_valid_reg [1:SQ_STAGES];
    logic [63:0] sq_rem_reg   [1:SQ_STAGES];
    logic [63:0] sq_root_reg  [1:SQ_STAGES];
    vec_t        sq_start_reg [1:SQ_STAGES];
    vec_t        sq_dir_reg   [1:SQ_STAGES];
    logic        sq_zero_reg  [1:SQ_STAGES];

    genvar j;
    generate
        for (j = 0; j < SQ_STAGES; j++)
        begin : g_sqrt
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
            logic        v_cur;
            logic [63:0] rem_cur;
            logic [63:0] root_cur;
            vec_t        start_cur;
            vec_t        dir_cur;
            logic        zero_cur;
            logic [64:0] trial;
            logic        ge;

            if (j == 0)
            begin : g_src
                assign v_cur     = in_valid;
                assign rem_cur   = in_ray.sum;
                assign root_cur  = '0;
                assign start_cur = in_ray.start;
                assign dir_cur   = in_ray.dir;
                assign zero_cur  = in_ray.dir_zero;
            end
            else
            begin : g_src
                assign v_cur     = sq_valid_reg[j];
                assign rem_cur   = sq_rem_reg[j];
                assign root_cur  = sq_root_reg[j];
                assign start_cur = sq_start_reg[j];
                assign dir_cur   = sq_dir_reg[j];
                assign zero_cur  = sq_zero_reg[j];
            end

            assign trial = {1'b0, root_cur} + {1'b0, BIT};
            assign ge    = {1'b0, rem_cur} >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_valid_reg[j+1] <= 1'b0;
                end
                else
                begin
                    sq_valid_reg[j+1] <= v_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                sq_rem_reg[j+1]   <= ge ? rem_cur - trial[63:0] : rem_cur;
                sq_root_reg[j+1]  <= ge ? (root_cur >> 1) + BIT : root_cur >> 1;
                sq_start_reg[j+1] <= start_cur;
                sq_dir_reg[j+1]   <= dir_cur;
                sq_zero_reg[j+1]  <= zero_cur;
            end
        end
    endgenerate

    // ---------------- unit direction: d * 2^16 / len ----------------
    logic [2:0][NUM_W-1:0] unit_num;
    logic [2:0][LEN_W-1:0] unit_den;
    unit_side_t            unit_in_side;
    logic                  unit_valid;
    logic [2:0][UQ_W-1:0]  unit_q;
    unit_side_t            unit_out_side;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [31:0] dabs;
            dabs = sq_dir_reg[SQ_STAGES][k][31] ? (~sq_dir_reg[SQ_STAGES][k] + 32'd1)
                                                : sq_dir_reg[SQ_STAGES][k];
            unit_num[k] = {dabs, 16'h0000};
            unit_den[k] = sq_root_reg[SQ_STAGES][LEN_W-1:0];
            unit_in_side.neg[k] = sq_dir_reg[SQ_STAGES][k][31];
        end
        unit_in_side.start = sq_start_reg[SQ_STAGES];
        unit_in_side.zero  = sq_zero_reg[SQ_STAGES];
    end

    rbfi_div #(
        .LANES (3),
        .NW    (NUM_W),
        .DW    (LEN_W),
        .QW    (UQ_W),
        .SW    ($bits(unit_side_t))
    ) u_unit_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid_reg[SQ_STAGES]),
        .num       (unit_num),
        .den       (unit_den),
        .in_side   (unit_in_side),
        .out_valid (unit_valid),
        .quo       (unit_q),
        .out_side  (unit_out_side)
    );

    // ---------------- face numerators ----------------
    logic                b_valid_reg;
    logic [2:0][U_W-1:0] b_u_reg, b_u_next;
    logic [2:0][UQ_W-1:0] b_umag_reg;
    logic [2:0]          b_ok_reg, b_ok_next;
    logic [5:0][32:0]    b_diff_reg, b_diff_next;
    vec_t                b_start_reg;
    logic                b_zero_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            b_u_next[a] = unit_out_side.neg[a] ? U_W'(-{1'b0, unit_q[a]})
                                               : {1'b0, unit_q[a]};
            b_ok_next[a] = unit_q[a] >= UQ_W'(rbfi_pkg::EPS_Q);
            b_diff_next[2*a]   = 33'($signed({box_high[a][31], box_high[a]})
                               - $signed({unit_out_side.start[a][31], unit_out_side.start[a]}));
            b_diff_next[2*a+1] = 33'($signed({box_low[a][31], box_low[a]})
                               - $signed({unit_out_side.start[a][31], unit_out_side.start[a]}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= unit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        b_u_reg     <= b_u_next;
        b_umag_reg  <= unit_q;
        b_ok_reg    <= b_ok_next;
        b_diff_reg  <= b_diff_next;
        b_start_reg <= unit_out_side.start;
        b_zero_reg  <= unit_out_side.zero;
    end

    // ---------------- t for all six faces ----------------
    logic [5:0][NUM_W-1:0] face_num;
    logic [5:0][UQ_W-1:0]  face_den;
    face_side_t            face_in_side;
    logic                  face_valid;
    logic [5:0][TQ_W-1:0]  face_q;
    face_side_t            face_out_side;

    always_comb
    begin
        for (int f = 0; f < 6; f++)
        begin
            logic [32:0] dmag;
            dmag = b_diff_reg[f][32] ? (~b_diff_reg[f] + 33'd1) : b_diff_reg[f];
            face_num[f] = {dmag[31:0], 16'h0000};
            face_den[f] = b_umag_reg[f/2];
            face_in_side.tneg[f] = b_diff_reg[f][32] ^ b_u_reg[f/2][U_W-1];
        end
        face_in_side.u     = b_u_reg;
        face_in_side.start = b_start_reg;
        face_in_side.ok    = b_ok_reg;
        face_in_side.zero  = b_zero_reg;
    end

    rbfi_div #(
        .LANES (6),
        .NW    (NUM_W),
        .DW    (UQ_W),
        .QW    (TQ_W),
        .SW    ($bits(face_side_t))
    ) u_face_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .num       (face_num),
        .den       (face_den),
        .in_side   (face_in_side),
        .out_valid (face_valid),
        .quo       (face_q),
        .out_side  (face_out_side)
    );

    // ---------------- signed t ----------------
    logic                c_valid_reg;
    logic [5:0][T_W-1:0] c_t_reg, c_t_next;
    logic [2:0][U_W-1:0] c_u_reg;
    vec_t                c_start_reg;
    logic [2:0]          c_ok_reg;
    logic                c_zero_reg;

    always_comb
    begin
        for (int f = 0; f < 6; f++)
        begin
            c_t_next[f] = face_out_side.tneg[f] ? T_W'(-{1'b0, face_q[f]})
                                                : {1'b0, face_q[f]};
        end
    end

    // ---------------- t * u products ----------------
    logic                          d_valid_reg;
    logic [5:0][2:0][PROD_W-1:0]   d_prod_reg, d_prod_next;
    logic [5:0][T_W-1:0]           d_t_reg;
    vec_t                          d_start_reg;
    logic [2:0]                    d_ok_reg;
    logic                          d_zero_reg;

    always_comb
    begin
        for (int f = 0; f < 6; f++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [PROD_W-1:0] pr;
                pr = $signed(c_t_reg[f]) * $signed(c_u_reg[k]);
                d_prod_next[f][k] = pr;
            end
        end
    end

    // ---------------- hit points and face tests ----------------
    logic                     e_valid_reg;
    logic [5:0]               e_cnt_reg, e_cnt_next;
    logic [5:0][T_W-1:0]      e_t_reg;
    logic [5:0][2:0][P_W-1:0] e_p_reg, e_p_next;

    always_comb
    begin
        for (int f = 0; f < 6; f++)
        begin
            logic signed [PROD_W-1:0] adj;
            logic signed [PROD_W-1:0] shq;
            logic in_b;
            logic in_c;
            for (int k = 0; k < 3; k++)
            begin
                // divide by 2^16 rounding toward zero
                adj = $signed(d_prod_reg[f][k])
                    + (d_prod_reg[f][k][PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
                shq = adj >>> 16;
                e_p_next[f][k] = P_W'($signed({{(P_W - 32){d_start_reg[k][31]}},
                                              d_start_reg[k]}) + $signed(shq[P_W-1:0]));
            end
            in_b = ($signed({{(P_W - 32){box_low[((f/2)+1)%3][31]}}, box_low[((f/2)+1)%3]})
                    <= $signed(e_p_next[f][((f/2)+1)%3]))
                && ($signed(e_p_next[f][((f/2)+1)%3])
                    <= $signed({{(P_W - 32){box_high[((f/2)+1)%3][31]}},
                                box_high[((f/2)+1)%3]}));
            in_c = ($signed({{(P_W - 32){box_low[((f/2)+2)%3][31]}}, box_low[((f/2)+2)%3]})
                    <= $signed(e_p_next[f][((f/2)+2)%3]))
                && ($signed(e_p_next[f][((f/2)+2)%3])
                    <= $signed({{(P_W - 32){box_high[((f/2)+2)%3][31]}},
                                box_high[((f/2)+2)%3]}));
            e_cnt_next[f] = d_ok_reg[f/2] && !d_zero_reg && in_b && in_c
                         && ($signed(d_t_reg[f]) >= T_MIN);
        end
    end

    // ---------------- nearest face, pairs then the rest ----------------
    logic             f_valid_reg;
    cand_t [2:0]      f_cand_reg, f_cand_next;
    logic             g_valid_reg;
    rbfi_pkg::result_t g_result_reg, g_result_next;

    always_comb
    begin
        cand_t lo_c;
        cand_t hi_c;
        for (int m = 0; m < 3; m++)
        begin
            lo_c.found = e_cnt_reg[2*m];
            lo_c.t     = e_t_reg[2*m];
            lo_c.p     = e_p_reg[2*m];
            lo_c.face  = rbfi_pkg::FACE_W'(2 * m);
            hi_c.found = e_cnt_reg[2*m+1];
            hi_c.t     = e_t_reg[2*m+1];
            hi_c.p     = e_p_reg[2*m+1];
            hi_c.face  = rbfi_pkg::FACE_W'(2 * m + 1);
            f_cand_next[m] = pick(lo_c, hi_c);
        end
    end

    always_comb
    begin
        cand_t best;
        best = pick(pick(f_cand_reg[0], f_cand_reg[1]), f_cand_reg[2]);
        g_result_next = '0;
        if (best.found)
        begin
            g_result_next.hit      = 1'b1;
            g_result_next.x        = sat32(best.p[0]);
            g_result_next.y        = sat32(best.p[1]);
            g_result_next.z        = sat32(best.p[2]);
            g_result_next.face     = best.face;
            g_result_next.distance = sat32({{(P_W - T_W){best.t[T_W-1]}}, best.t});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= face_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_t_reg      <= c_t_next;
        c_u_reg      <= face_out_side.u;
        c_start_reg  <= face_out_side.start;
        c_ok_reg     <= face_out_side.ok;
        c_zero_reg   <= face_out_side.zero;
        d_prod_reg   <= d_prod_next;
        d_t_reg      <= c_t_reg;
        d_start_reg  <= c_start_reg;
        d_ok_reg     <= c_ok_reg;
        d_zero_reg   <= c_zero_reg;
        e_cnt_reg    <= e_cnt_next;
        e_t_reg      <= d_t_reg;
        e_p_reg      <= e_p_next;
        f_cand_reg   <= f_cand_next;
        g_result_reg <= g_result_next;
    end

    assign out_valid  = g_valid_reg;
    assign out_result = g_result_reg;

endmodule

@@ rtl/ray_box_face_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_box_face_intersect
// nearest face hit of a ray against the configured axis-aligned box
// ----------------------------------------------------------------------------
// a ray is taken at a rising edge with start high and busy low; start_* and
// dir_* are signed Q16.16, the direction need not be unit length.
// each ray gives one result beat, done high for one cycle with hit, hit_x,
// hit_y, hit_z, face and distance; a miss reports all fields zero.
// the path runs through two front stages, the queue, a 32 stage square root,
// a 17 stage divider for the unit direction, a 42 stage divider for the face
// distances, then products, point tests and a two level nearest-face pick.
// throughput is one ray per cycle; busy rises only when the front queue
// lacks room, which does not happen while the back drains every cycle.
// the result side cannot stall, so the back never holds a beat.
// box corners are written through cfg_valid/cfg_index/cfg_data; the user
// must write them only while no ray is in flight, which the block itself
// leaves unchecked; cfg_ready is always high. reset empties the pipeline and
// sets the box to the unit cube from the origin.
// ----------------------------------------------------------------------------
module ray_box_face_intersect #(
    parameter int QUEUE_DEPTH = rbfi_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rbfi_pkg::COORD_W-1:0] start_x,
    input  logic signed [rbfi_pkg::COORD_W-1:0] start_y,
    input  logic signed [rbfi_pkg::COORD_W-1:0] start_z,
    input  logic signed [rbfi_pkg::COORD_W-1:0] dir_x,
    input  logic signed [rbfi_pkg::COORD_W-1:0] dir_y,
    input  logic signed [rbfi_pkg::COORD_W-1:0] dir_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbfi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbfi_pkg::COORD_W-1:0]        cfg_data,
    output logic                                done,
    output logic                                hit,
    output logic signed [rbfi_pkg::COORD_W-1:0] hit_x,
    output logic signed [rbfi_pkg::COORD_W-1:0] hit_y,
    output logic signed [rbfi_pkg::COORD_W-1:0] hit_z,
    output logic [rbfi_pkg::FACE_W-1:0]         face,
    output logic signed [rbfi_pkg::COORD_W-1:0] distance
);

    logic [2:0][rbfi_pkg::COORD_W-1:0] box_low_reg, box_low_next;
    logic [2:0][rbfi_pkg::COORD_W-1:0] box_high_reg, box_high_next;
    logic                              accept;
    logic                              push;
    rbfi_pkg::ray_t                    push_data;
    rbfi_pkg::ray_t                    pop_data;
    rbfi_pkg::queue_status_t           q_status;
    logic                              pop;
    logic                              res_valid;
    rbfi_pkg::result_t                 res;

    assign cfg_ready = 1'b1;
    assign busy      = !q_status.room;
    assign accept    = start && !busy;
    assign pop       = !q_status.empty;

    always_comb
    begin
        box_low_next  = box_low_reg;
        box_high_next = box_high_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rbfi_pkg::CFG_BOX_LOW_X:  box_low_next[0]  = cfg_data;
                rbfi_pkg::CFG_BOX_LOW_Y:  box_low_next[1]  = cfg_data;
                rbfi_pkg::CFG_BOX_LOW_Z:  box_low_next[2]  = cfg_data;
                rbfi_pkg::CFG_BOX_HIGH_X: box_high_next[0] = cfg_data;
                rbfi_pkg::CFG_BOX_HIGH_Y: box_high_next[1] = cfg_data;
                rbfi_pkg::CFG_BOX_HIGH_Z: box_high_next[2] = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_low_reg  <= {3{rbfi_pkg::BOX_LOW_RESET}};
            box_high_reg <= {3{rbfi_pkg::BOX_HIGH_RESET}};
        end
        else
        begin
            box_low_reg  <= box_low_next;
            box_high_reg <= box_high_next;
        end
    end

    rbfi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_pos ({start_z, start_y, start_x}),
        .dir       ({dir_z, dir_y, dir_x}),
        .push      (push),
        .push_data (push_data)
    );

    rbfi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    rbfi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pop),
        .in_ray     (pop_data),
        .box_low    (box_low_reg),
        .box_high   (box_high_reg),
        .out_valid  (res_valid),
        .out_result (res)
    );

    assign done     = res_valid;
    assign hit      = res.hit;
    assign hit_x    = res.x;
    assign hit_y    = res.y;
    assign hit_z    = res.z;
    assign face     = res.face;
    assign distance = res.distance;

endmodule
